// ----- rtl/core/owm_pkg.sv -----
package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_sample_time;
        logic [9:0] reset_recovery_time;
        logic [5:0] short_low_time;
        logic [5:0] read_sample_delay;
        logic [6:0] long_low_time;
        logic [6:0] slot_length;
    } t_cfg;

    localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [7:0] PRESENCE_DEF      = 8'd70;
    localparam logic [9:0] RECOVERY_DEF      = 10'd410;
    localparam logic [5:0] SHORT_LOW_DEF     = 6'd6;
    localparam logic [5:0] READ_SAMPLE_DEF   = 6'd9;
    localparam logic [6:0] LONG_LOW_DEF      = 7'd60;
    localparam logic [6:0] SLOT_LENGTH_DEF   = 7'd70;

endpackage

// ----- rtl/core/owm_cfg.sv -----
module owm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [owm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [owm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output owm_pkg::t_cfg                   o_cfg
);
    import owm_pkg::*;

    typedef enum logic [2:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRESENCE    = 3'd1,
        REG_RECOVERY    = 3'd2,
        REG_SHORT_LOW   = 3'd3,
        REG_READ_SAMPLE = 3'd4,
        REG_LONG_LOW    = 3'd5,
        REG_SLOT_LENGTH = 3'd6
    } t_reg_idx;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time       <= RESET_LOW_DEF;
            r_cfg.presence_sample_time <= PRESENCE_DEF;
            r_cfg.reset_recovery_time  <= RECOVERY_DEF;
            r_cfg.short_low_time       <= SHORT_LOW_DEF;
            r_cfg.read_sample_delay    <= READ_SAMPLE_DEF;
            r_cfg.long_low_time        <= LONG_LOW_DEF;
            r_cfg.slot_length          <= SLOT_LENGTH_DEF;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RESET_LOW:   r_cfg.reset_low_time       <= pwdata[9:0];
                REG_PRESENCE:    r_cfg.presence_sample_time <= pwdata[7:0];
                REG_RECOVERY:    r_cfg.reset_recovery_time  <= pwdata[9:0];
                REG_SHORT_LOW:   r_cfg.short_low_time       <= pwdata[5:0];
                REG_READ_SAMPLE: r_cfg.read_sample_delay    <= pwdata[5:0];
                REG_LONG_LOW:    r_cfg.long_low_time        <= pwdata[6:0];
                REG_SLOT_LENGTH: r_cfg.slot_length          <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RESET_LOW:   prdata = APB_DATA_W'(r_cfg.reset_low_time);
            REG_PRESENCE:    prdata = APB_DATA_W'(r_cfg.presence_sample_time);
            REG_RECOVERY:    prdata = APB_DATA_W'(r_cfg.reset_recovery_time);
            REG_SHORT_LOW:   prdata = APB_DATA_W'(r_cfg.short_low_time);
            REG_READ_SAMPLE: prdata = APB_DATA_W'(r_cfg.read_sample_delay);
            REG_LONG_LOW:    prdata = APB_DATA_W'(r_cfg.long_low_time);
            REG_SLOT_LENGTH: prdata = APB_DATA_W'(r_cfg.slot_length);
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/one_wire_bus_master.sv -----
// 1-Wire bus master stepped by command beats (reset, write byte, read byte) and
// by one-microsecond tick beats that carry the sampled line level. Every input
// beat yields exactly one result beat with the line drive, busy, done, presence,
// read byte and reject flags. Throughput is one beat per clock while results
// are taken. A beat accepted into the input register moves into the result
// register once that register is free, and is offered from then on. While a
// result waits downstream the input register takes one more beat, then o_ready
// drops until the result is taken.
// Timing registers sit on the APB port at byte addresses 0x00 (reset low),
// 0x04 (presence sample), 0x08 (reset recovery), 0x0C (short low), 0x10 (read
// sample delay), 0x14 (long low) and 0x18 (slot length); write them only while
// the block is idle. Zero-length phases that follow another phase resolve within the same tick.
module one_wire_bus_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_line_level,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_drive_low,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic                            o_device_present,
    output logic [7:0]                      o_read_value,
    output logic                            o_rejected,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [owm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [owm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import owm_pkg::*;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE - 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_RST_LOW   = 7'b0000010,
        PH_RST_WAIT  = 7'b0000100,
        PH_RST_REC   = 7'b0001000,
        PH_SLOT_LOW  = 7'b0010000,
        PH_READ_WAIT = 7'b0100000,
        PH_SLOT_REST = 7'b1000000
    } t_phase;

    t_cfg cfg;

    owm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register
    logic                     r_in_valid;
    t_opcode                  r_in_opcode;
    logic [BITS_PER_BYTE-1:0] r_in_data;
    logic                     r_in_line;

    // bus state
    t_phase                   r_phase;
    logic [9:0]               r_time_count;
    logic [BIT_W-1:0]         r_bit_number;
    logic [BITS_PER_BYTE-1:0] r_shift_byte;
    logic                     r_presence_seen;
    logic                     r_reading_mode;

    // result register
    logic                     r_out_valid;
    logic                     r_drive_low;
    logic                     r_busy;
    logic                     r_done;
    logic                     r_present;
    logic [BITS_PER_BYTE-1:0] r_read_value;
    logic                     r_rejected;

    t_phase                   n_phase;
    logic [9:0]               n_time_count;
    logic [BIT_W-1:0]         n_bit_number;
    logic [BITS_PER_BYTE-1:0] n_shift_byte;
    logic                     n_presence_seen;
    logic                     n_reading_mode;
    logic                     fin_reset;
    logic                     fin_slot;
    logic                     rej;

    logic                     adv;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    // phase length of the current phase
    logic [6:0]  cur_low;
    logic [7:0]  used;
    logic        zr_cur;
    logic [6:0]  rest_len;
    logic [9:0]  phase_len;
    logic [9:0]  tc;
    logic        tick_end;
    logic        z_short;
    logic        z_long;
    logic        z_wait;
    logic        z_slot;

    assign z_short  = (cfg.short_low_time == '0);
    assign z_long   = (cfg.long_low_time == '0);
    assign z_wait   = (cfg.read_sample_delay == '0);
    assign z_slot   = (cfg.slot_length == '0);
    assign cur_low  = (r_reading_mode || r_shift_byte[0]) ? {1'b0, cfg.short_low_time}
                                                          : cfg.long_low_time;
    assign used     = {1'b0, cur_low}
                    + (r_reading_mode ? {2'b00, cfg.read_sample_delay} : 8'd0);
    assign zr_cur   = ({1'b0, cfg.slot_length} <= used);
    assign rest_len = zr_cur ? 7'd0 : 7'(({1'b0, cfg.slot_length} - used));
    assign tc       = r_time_count + 10'd1;
    assign tick_end = (tc >= phase_len);

    always_comb begin
        case (r_phase)
            PH_RST_LOW:   phase_len = cfg.reset_low_time;
            PH_RST_WAIT:  phase_len = {2'b00, cfg.presence_sample_time};
            PH_RST_REC:   phase_len = cfg.reset_recovery_time;
            PH_SLOT_LOW:  phase_len = 10'(cur_low);
            PH_READ_WAIT: phase_len = 10'(cfg.read_sample_delay);
            PH_SLOT_REST: phase_len = 10'(rest_len);
            default:      phase_len = '0;
        endcase
    end

    // Slot path: finish the current slot, skip over slots that take no time,
    // stop inside the first slot that still has time left, or finish the byte.
    logic                     a_complete;
    t_phase                   a_phase;
    logic [BITS_PER_BYTE-1:0] a_shift;
    logic [BIT_W-1:0]         rem;
    logic [BIT_W-1:0]         nb;
    logic [BITS_PER_BYTE-1:0] zfull;
    logic                     found;
    logic [BIT_W-1:0]         jsel;
    t_phase                   s_phase;
    logic [BIT_W-1:0]         s_bit;
    logic [BITS_PER_BYTE-1:0] s_shift;
    logic                     s_fin;

    assign rem = LAST_BIT - r_bit_number;
    assign nb  = r_bit_number + BIT_W'(1);

    always_comb begin
        a_complete = 1'b0;
        a_phase    = r_phase;
        a_shift    = r_shift_byte;
        case (r_phase)
            PH_SLOT_LOW: begin
                if (r_reading_mode) begin
                    if (z_wait) begin
                        a_shift = {r_in_line, r_shift_byte[BITS_PER_BYTE-1:1]};
                        if (zr_cur) a_complete = 1'b1;
                        else a_phase = PH_SLOT_REST;
                    end else begin
                        a_phase = PH_READ_WAIT;
                    end
                end else if (zr_cur) begin
                    a_complete = 1'b1;
                    a_shift    = r_shift_byte >> 1;
                end else begin
                    a_phase = PH_SLOT_REST;
                end
            end
            PH_READ_WAIT: begin
                a_shift = {r_in_line, r_shift_byte[BITS_PER_BYTE-1:1]};
                if (zr_cur) a_complete = 1'b1;
                else a_phase = PH_SLOT_REST;
            end
            PH_SLOT_REST: begin
                a_complete = 1'b1;
                if (!r_reading_mode) a_shift = r_shift_byte >> 1;
            end
            default: a_complete = 1'b0;
        endcase
    end

    // write mode: first remaining bit whose slot takes time
    always_comb begin
        for (int j = 0; j < BITS_PER_BYTE; j++) begin
            zfull[j] = z_slot && (a_shift[j] ? z_short : z_long);
        end
        found = 1'b0;
        jsel  = '0;
        for (int j = BITS_PER_BYTE - 2; j >= 0; j--) begin
            if ((j < int'(rem)) && !zfull[j]) begin
                found = 1'b1;
                jsel  = BIT_W'(j);
            end
        end
    end

    always_comb begin
        s_phase = a_phase;
        s_bit   = r_bit_number;
        s_shift = a_shift;
        s_fin   = 1'b0;
        if (a_complete) begin
            if (r_bit_number == LAST_BIT) begin
                s_phase = PH_IDLE;
                s_fin   = 1'b1;
            end else if (r_reading_mode) begin
                if (z_short && z_wait && zr_cur) begin
                    // every remaining slot samples this tick's level
                    s_phase = PH_IDLE;
                    s_fin   = 1'b1;
                    s_shift = (a_shift >> rem)
                            | (r_in_line ? ~({BITS_PER_BYTE{1'b1}} >> rem) : '0);
                end else begin
                    s_bit = nb;
                    if (!z_short) begin
                        s_phase = PH_SLOT_LOW;
                    end else if (!z_wait) begin
                        s_phase = PH_READ_WAIT;
                    end else begin
                        s_shift = {r_in_line, a_shift[BITS_PER_BYTE-1:1]};
                        s_phase = PH_SLOT_REST;
                    end
                end
            end else if (found) begin
                s_bit   = nb + jsel;
                s_shift = a_shift >> jsel;
                s_phase = (a_shift[jsel] ? z_short : z_long) ? PH_SLOT_REST : PH_SLOT_LOW;
            end else begin
                s_phase = PH_IDLE;
                s_fin   = 1'b1;
                s_shift = '0;
            end
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_time_count    = r_time_count;
        n_bit_number    = r_bit_number;
        n_shift_byte    = r_shift_byte;
        n_presence_seen = r_presence_seen;
        n_reading_mode  = r_reading_mode;
        fin_reset       = 1'b0;
        fin_slot        = 1'b0;
        rej             = 1'b0;
        if (r_in_opcode == OP_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (!tick_end) begin
                    n_time_count = tc;
                end else begin
                    n_time_count = '0;
                    case (r_phase)
                        PH_RST_LOW: begin
                            if (cfg.presence_sample_time == '0) begin
                                n_presence_seen = !r_in_line;
                                if (cfg.reset_recovery_time == '0) begin
                                    n_phase   = PH_IDLE;
                                    fin_reset = 1'b1;
                                end else begin
                                    n_phase = PH_RST_REC;
                                end
                            end else begin
                                n_phase = PH_RST_WAIT;
                            end
                        end
                        PH_RST_WAIT: begin
                            n_presence_seen = !r_in_line;
                            if (cfg.reset_recovery_time == '0) begin
                                n_phase   = PH_IDLE;
                                fin_reset = 1'b1;
                            end else begin
                                n_phase = PH_RST_REC;
                            end
                        end
                        PH_RST_REC: begin
                            n_phase   = PH_IDLE;
                            fin_reset = 1'b1;
                        end
                        PH_SLOT_LOW, PH_READ_WAIT, PH_SLOT_REST: begin
                            n_phase      = s_phase;
                            n_bit_number = s_bit;
                            n_shift_byte = s_shift;
                            fin_slot     = s_fin;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            rej = 1'b1;
        end else begin
            n_time_count = '0;
            n_bit_number = '0;
            case (r_in_opcode)
                OP_RESET: begin
                    n_presence_seen = 1'b0;
                    n_reading_mode  = 1'b0;
                    n_phase         = PH_RST_LOW;
                end
                OP_WRITE: begin
                    n_shift_byte   = r_in_data;
                    n_reading_mode = 1'b0;
                    n_phase        = PH_SLOT_LOW;
                end
                default: begin
                    n_shift_byte   = '0;
                    n_reading_mode = 1'b1;
                    n_phase        = PH_SLOT_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= PH_IDLE;
            r_time_count    <= '0;
            r_bit_number    <= '0;
            r_shift_byte    <= '0;
            r_presence_seen <= 1'b0;
            r_reading_mode  <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (adv) begin
                r_out_valid     <= 1'b1;
                r_phase         <= n_phase;
                r_time_count    <= n_time_count;
                r_bit_number    <= n_bit_number;
                r_shift_byte    <= n_shift_byte;
                r_presence_seen <= n_presence_seen;
                r_reading_mode  <= n_reading_mode;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_opcode <= t_opcode'(i_opcode);
            r_in_data   <= i_data_byte;
            r_in_line   <= i_line_level;
        end
        if (adv) begin
            r_drive_low  <= (n_phase == PH_RST_LOW) || (n_phase == PH_SLOT_LOW);
            r_busy       <= (n_phase != PH_IDLE);
            r_done       <= fin_reset || fin_slot;
            r_present    <= fin_reset && n_presence_seen;
            r_read_value <= (fin_slot && n_reading_mode) ? n_shift_byte : '0;
            r_rejected   <= rej;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_drive_low      = r_drive_low;
    assign o_busy_res       = r_busy;
    assign o_done_res       = r_done;
    assign o_device_present = r_present;
    assign o_read_value     = r_read_value;
    assign o_rejected       = r_rejected;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_busy_res && !o_done_res)
        else $error("reject without a sequence in progress");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_low |-> o_busy_res)
        else $error("line driven low while idle");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_time_count == '0)
        else $error("time count left over in idle");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_opcode) && $stable(r_in_line))
        else $error("buffered beat lost or overwritten");

endmodule
